>>> sv/latency_window_statistics_top_defines.svh
// Assertion macros shared by the checker of the latency window statistics block.
// Needs nothing but a clock and reset in the scope that uses them.
`ifndef LATENCY_WINDOW_STATISTICS_TOP_DEFINES_SVH
`define LATENCY_WINDOW_STATISTICS_TOP_DEFINES_SVH
// implication checked every clock, muted in reset
`define LWS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define LWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/lws_pkg.sv
// Package for the latency window statistics block: command codes, sizes, types.
// Used by lws_front, lws_back and the top module.
`timescale 1ns / 1ps
package lws_pkg;
  localparam int Window = 1024;
  localparam int PtrW = $clog2(Window);
  localparam int CntW = $clog2(Window + 1);
  localparam int SumW = 32 + CntW;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  typedef enum logic [2:0] {
    CMD_PACKET = 3'd0,
    CMD_ORDER  = 3'd1,
    CMD_TRADE  = 3'd2,
    CMD_REJECT = 3'd3,
    CMD_SAMPLE = 3'd4,
    CMD_QUEUE  = 3'd5,
    CMD_SNAP   = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  // item handed from front to back through the queue
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] value;
  } work_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDOLD,
    ST_WROLD,
    ST_SCAN,
    ST_DIV,
    ST_RANK,
    ST_RANKWAIT,
    ST_RANKCMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] packets;
    logic [63:0] orders;
    logic [63:0] trades;
    logic [63:0] rejections;
    logic [31:0] queue;
  } counts_t;
endpackage

>>> sv/lws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
module lws_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/lws_front.sv
// Front end: accepts beats, updates the event counters, queues other work.
// Depends on lws_pkg.
`timescale 1ns / 1ps
module lws_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           command,
  input  logic [31:0]          value,
  output lws_pkg::counts_t     counts,
  output logic                 q_valid,
  output lws_pkg::work_t       q_data,
  input  logic                 q_pop
);
  import lws_pkg::*;

  work_t            qmem [QDepth];
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW:0]   level;
  logic             accept;
  logic             push;
  logic             snap_busy;
  counts_t          live;
  cmd_t             cmd;

  assign cmd      = cmd_t'(command);
  // one snapshot in flight at a time, so the counter copy it carries stays put
  assign in_stall = (level == (QPtrW + 1)'(QDepth)) || (snap_busy && cmd == CMD_SNAP);
  assign accept   = in_valid && !in_stall;
  // counter and queue-level commands are done here; samples and snapshots go back
  assign push     = accept && (cmd == CMD_SAMPLE || cmd == CMD_SNAP);
  assign q_valid  = (level != '0);
  assign q_data   = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      counts    <= '0;
      snap_busy <= 1'b0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      level     <= '0;
    end else begin
      if (accept) begin
        unique case (cmd)
          CMD_PACKET: live.packets    <= live.packets + 64'd1;
          CMD_ORDER:  live.orders     <= live.orders + 64'd1;
          CMD_TRADE:  live.trades     <= live.trades + 64'd1;
          CMD_REJECT: live.rejections <= live.rejections + 64'd1;
          CMD_QUEUE:  live.queue      <= value;
          CMD_SNAP:   counts          <= live;
          default: ;
        endcase
      end
      if (push && cmd == CMD_SNAP) begin
        snap_busy <= 1'b1;
      end else if (q_pop && q_data.cmd == CMD_SNAP) begin
        snap_busy <= 1'b0;
      end
      if (push) begin
        qmem[wr_ptr] <= '{cmd: cmd, value: value};
        wr_ptr       <= wr_ptr + QPtrW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      level <= level + (QPtrW + 1)'(push) - (QPtrW + 1)'(q_pop);
    end
  end
endmodule

>>> sv/lws_back.sv
// Back end: sample window ring, running sum, snapshot scan, divider, rank select.
// Depends on lws_pkg and lws_ram.
`timescale 1ns / 1ps
module lws_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  lws_pkg::work_t   q_data,
  output logic             q_pop,
  input  lws_pkg::counts_t counts,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      packet_count,
  output logic [63:0]      order_count,
  output logic [63:0]      trade_count,
  output logic [63:0]      reject_count,
  output logic [31:0]      queue_level,
  output logic [10:0]      sample_count,
  output logic [31:0]      min_ns,
  output logic [31:0]      max_ns,
  output logic [31:0]      mean_ns,
  output logic [31:0]      median_ns,
  output logic [31:0]      p95_ns,
  output logic [31:0]      p99_ns
);
  import lws_pkg::*;

  state_t           state, state_next;
  logic [PtrW-1:0]  wptr;
  logic [CntW-1:0]  fill;
  logic [SumW-1:0]  sum;
  logic [31:0]      pend;

  logic             ram_we;
  logic [PtrW-1:0]  ram_waddr;
  logic [PtrW-1:0]  ram_raddr;
  logic [31:0]      ram_rdata;

  // scan / rank loop state
  logic [CntW-1:0]  idx;        // read issue index
  logic [CntW-1:0]  pos;        // index of data arriving now
  logic             rd_live;
  logic [31:0]      mn, mx;
  logic [31:0]      cand;       // candidate whose rank is being counted
  logic [CntW-1:0]  ci;         // candidate index
  logic [CntW-1:0]  lt_cnt, le_cnt;
  logic [CntW-1:0]  k50, k95, k99;
  logic [2:0]       found;
  logic [31:0]      r50, r95, r99;
  logic             k50_hit, k95_hit, k99_hit;

  // divider
  logic [SumW-1:0]  rem;
  logic [31:0]      quo;
  logic [5:0]       dstep;
  logic [SumW-1:0]  div_try;

  // percentile index: floor((n-1)*p/100) via multiply by reciprocal then correction
  function automatic logic [CntW-1:0] pidx(input logic [CntW-1:0] nm1,
                                           input logic [6:0] p);
    logic [CntW+6:0] prod;
    logic [CntW+6:0] q;
    begin
      prod = (CntW + 7)'(nm1) * (CntW + 7)'(p);
      q    = (CntW + 7)'(((CntW + 7 + 16)'(prod) * (CntW + 7 + 16)'(655)) >> 16);
      if (prod - q * (CntW + 7)'(100) >= (CntW + 7)'(100)) begin
        q = q + (CntW + 7)'(1);
      end
      pidx = CntW'(q);
    end
  endfunction

  lws_ram #(.Width(32), .Depth(Window)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_data.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = wptr;
  assign ram_raddr = (state == ST_IDLE) ? wptr : idx[PtrW-1:0];
  // high part of the sum starts in rem, low part shifts in from quo
  assign div_try   = {rem[SumW-2:0], quo[31]};

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_data.cmd == CMD_SAMPLE) begin
            if (fill == CntW'(Window)) begin
              state_next = ST_RDOLD;
            end else begin
              ram_we = 1'b1;
              q_pop  = 1'b1;
            end
          end else if (fill == '0) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_RDOLD: state_next = ST_WROLD;
      ST_WROLD: begin
        ram_we     = 1'b1;
        q_pop      = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: if (rd_live && pos == fill - CntW'(1)) state_next = ST_DIV;
      ST_DIV:  if (dstep == 6'd32) state_next = ST_RANK;
      ST_RANK: state_next = ST_RANKWAIT;
      ST_RANKWAIT: if (rd_live && pos == fill - CntW'(1)) state_next = ST_RANKCMP;
      ST_RANKCMP: begin
        if ((found | {k99_hit, k95_hit, k50_hit}) == 3'b111 || ci == fill - CntW'(1)) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_RANK;
        end
      end
      ST_OUT: begin
        if (!out_valid) begin
          q_pop      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // candidate is at sorted rank k iff lt <= k < le
  assign k50_hit = (lt_cnt <= k50) && (k50 < le_cnt);
  assign k95_hit = (lt_cnt <= k95) && (k95 < le_cnt);
  assign k99_hit = (lt_cnt <= k99) && (k99 < le_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wptr      <= '0;
      fill      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
      rd_live   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        wptr <= (wptr == PtrW'(Window - 1)) ? '0 : wptr + PtrW'(1);
        if (state == ST_WROLD) begin
          sum <= sum - SumW'(pend) + SumW'(q_data.value);
        end else begin
          sum  <= sum + SumW'(q_data.value);
          fill <= fill + CntW'(1);
        end
      end
      // issued reads land in the following cycle
      rd_live <= 1'b0;
      if ((state == ST_IDLE && state_next == ST_SCAN) || state == ST_RANK ||
          ((state == ST_SCAN || state == ST_RANKWAIT) && idx != fill)) begin
        rd_live <= (state == ST_IDLE || state == ST_RANK) ? 1'b0 : 1'b1;
      end
      if (state == ST_OUT && state_next == ST_IDLE) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= idx;
    unique case (state)
      ST_IDLE: begin
        idx   <= '0;
        mn    <= '1;
        mx    <= '0;
        ci    <= '0;
        found <= '0;
        k50   <= pidx(fill - CntW'(1), 7'd50);
        k95   <= pidx(fill - CntW'(1), 7'd95);
        k99   <= pidx(fill - CntW'(1), 7'd99);
      end
      ST_RDOLD: pend <= ram_rdata;
      ST_WROLD: ;
      ST_SCAN: begin
        if (idx != fill) idx <= idx + CntW'(1);
        if (rd_live) begin
          if (ram_rdata < mn) mn <= ram_rdata;
          if (ram_rdata > mx) mx <= ram_rdata;
        end
        rem   <= SumW'(sum[SumW-1:32]);
        quo   <= sum[31:0];
        dstep <= '0;
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle (quotient fits 32 bits)
        if (dstep != 6'd32) begin
          if (div_try >= SumW'(fill)) begin
            rem <= div_try - SumW'(fill);
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= div_try;
            quo <= {quo[30:0], 1'b0};
          end
          dstep <= dstep + 6'd1;
        end
        idx <= ci;
      end
      ST_RANK: begin
        // ram_raddr is ci this cycle; capture candidate next cycle
        idx    <= '0;
        lt_cnt <= '0;
        le_cnt <= '0;
      end
      ST_RANKWAIT: begin
        if (idx == '0 && !rd_live && pos == ci) cand <= ram_rdata;
        if (idx != fill) idx <= idx + CntW'(1);
        if (rd_live) begin
          if (ram_rdata < cand)  lt_cnt <= lt_cnt + CntW'(1);
          if (ram_rdata <= cand) le_cnt <= le_cnt + CntW'(1);
        end
      end
      ST_RANKCMP: begin
        if (k50_hit && !found[0]) r50 <= cand;
        if (k95_hit && !found[1]) r95 <= cand;
        if (k99_hit && !found[2]) r99 <= cand;
        found <= found | {k99_hit, k95_hit, k50_hit};
        ci    <= ci + CntW'(1);
        idx   <= ci + CntW'(1);
      end
      ST_OUT: begin
        if (!out_valid) begin
          packet_count <= counts.packets;
          order_count  <= counts.orders;
          trade_count  <= counts.trades;
          reject_count <= counts.rejections;
          queue_level  <= counts.queue;
          sample_count <= 11'(fill);
          min_ns       <= (fill == '0) ? '0 : mn;
          max_ns       <= (fill == '0) ? '0 : mx;
          mean_ns      <= (fill == '0) ? '0 : quo;
          median_ns    <= (fill == '0) ? '0 : r50;
          p95_ns       <= (fill == '0) ? '0 : r95;
          p99_ns       <= (fill == '0) ? '0 : r99;
        end
      end
      default: ;
    endcase
  end
endmodule

>>> sv/latency_window_statistics_top.sv
// Latency window statistics monitor. Counter, queue-level and unused commands are
// done in the front end. Samples queue to the back end; once the 1024-entry window
// is full, each one first reads the old value it overwrites, for the running sum.
// A snapshot scans the window RAM once for min/max, divides the sum by the sample
// count, then ranks candidates by one RAM pass each (at most one per sample) until the
// 50/95/99 percentile ranks are found; these passes share the single read port of
// the window RAM. A 4-beat queue decouples the sides, so counter beats keep flowing
// while a snapshot is worked on, as long as the queue has room; the snapshot takes
// its counter copy when accepted, and a second snapshot beat stalls at the input
// until the first one has been loaded into the output register.
`timescale 1ns / 1ps
module latency_window_statistics_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] packet_count,
  output logic [63:0] order_count,
  output logic [63:0] trade_count,
  output logic [63:0] reject_count,
  output logic [31:0] queue_level,
  output logic [10:0] sample_count,
  output logic [31:0] min_ns,
  output logic [31:0] max_ns,
  output logic [31:0] mean_ns,
  output logic [31:0] median_ns,
  output logic [31:0] p95_ns,
  output logic [31:0] p99_ns
);
  import lws_pkg::*;

  counts_t counts;
  logic    q_valid;
  work_t   q_data;
  logic    q_pop;

  lws_front u_front (
    .clk, .rst, .in_valid, .in_stall, .command, .value,
    .counts, .q_valid, .q_data, .q_pop
  );

  lws_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .counts,
    .out_valid, .out_stall, .packet_count, .order_count, .trade_count,
    .reject_count, .queue_level, .sample_count, .min_ns, .max_ns, .mean_ns,
    .median_ns, .p95_ns, .p99_ns
  );
endmodule

>>> sv/lws_checker.sv
// Port-level checker for the latency window statistics block, bound to the top.
// Depends on latency_window_statistics_top_defines.svh.
`timescale 1ns / 1ps
`include "latency_window_statistics_top_defines.svh"
module lws_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] sample_count,
  input logic [31:0] min_ns,
  input logic [31:0] max_ns,
  input logic [31:0] mean_ns,
  input logic [31:0] median_ns
);
  `LWS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(median_ns))
  `LWS_ASSERT_IMP(a_count, out_valid, sample_count <= 11'd1024)
  `LWS_ASSERT_IMP(a_empty, out_valid && sample_count == 11'd0, max_ns == 32'd0)
  `LWS_ASSERT_IMP(a_order, out_valid && sample_count != 11'd0,
    min_ns <= median_ns && median_ns <= max_ns && min_ns <= mean_ns)
endmodule

bind latency_window_statistics_top lws_checker u_chk (.*);
